// ----- rtl/ebnd_pkg.sv -----
// ----------------------------------------------------------------------------
// ebnd_pkg
// shared types, codes and alphabet tables for the base-n entropy decoder
// ----------------------------------------------------------------------------
package ebnd_pkg;

    localparam int unsigned MAX_ENTROPY_BITS = 256;
    localparam int unsigned DIGIT_BITS       = 6;
    localparam int unsigned BYTE_COUNT_BITS  = $clog2(MAX_ENTROPY_BITS / 8 + 1);
    localparam int unsigned POS_BITS         = $clog2(MAX_ENTROPY_BITS);

    typedef logic [MAX_ENTROPY_BITS-1:0] store_t;

    typedef enum logic [2:0] {
        STATUS_OK          = 3'd0,
        STATUS_EMPTY       = 3'd1,
        STATUS_BAD_CHAR    = 3'd2,
        STATUS_BAD_FINAL   = 3'd3,
        STATUS_BAD_LENGTH  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BASE_4  = 2'd0,
        BASE_8  = 2'd1,
        BASE_32 = 2'd2,
        BASE_64 = 2'd3
    } base_t;

    typedef enum logic [1:0] {
        CFG_BASE_SELECT = 2'd0,
        CFG_WORD_COUNT  = 2'd1
    } cfg_index_t;

    localparam base_t      BASE_RESET       = BASE_64;
    localparam logic [2:0] WORD_COUNT_RESET = 3'd4;

    // bech32 alphabet, first character in the top byte
    localparam logic [255:0] BECH32_STR = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    // digit geometry for one alphabet and one entropy length
    typedef struct packed {
        logic [2:0]                 width;     // bits per full digit
        logic [2:0]                 rem;       // bits left for the short tail
        logic [7:0]                 full;      // number of full digits
        logic [7:0]                 expected;  // digits in a well formed text
        logic [BYTE_COUNT_BITS-1:0] bytes;     // entropy bytes
    } geom_t;

    typedef struct packed {
        logic                  valid;
        logic [DIGIT_BITS-1:0] value;
    } digit_t;

    function automatic geom_t geom(input base_t b, input logic [2:0] wsel);
        geom_t      g;
        logic [2:0] w;
        w       = (wsel > 3'd4) ? 3'd4 : wsel;
        g       = '0;
        g.bytes = BYTE_COUNT_BITS'(16 + 4 * int'(w));
        case (b)
            BASE_4: begin
                g.width = 3'd2;
                g.rem   = 3'd0;
                g.full  = 8'(64 + 16 * int'(w));
            end
            BASE_8: begin
                g.width = 3'd3;
                case (w)
                    3'd0:    begin g.full = 8'd42; g.rem = 3'd2; end
                    3'd1:    begin g.full = 8'd53; g.rem = 3'd1; end
                    3'd2:    begin g.full = 8'd64; g.rem = 3'd0; end
                    3'd3:    begin g.full = 8'd74; g.rem = 3'd2; end
                    default: begin g.full = 8'd85; g.rem = 3'd1; end
                endcase
            end
            BASE_32: begin
                g.width = 3'd5;
                case (w)
                    3'd0:    begin g.full = 8'd25; g.rem = 3'd3; end
                    3'd1:    begin g.full = 8'd32; g.rem = 3'd0; end
                    3'd2:    begin g.full = 8'd38; g.rem = 3'd2; end
                    3'd3:    begin g.full = 8'd44; g.rem = 3'd4; end
                    default: begin g.full = 8'd51; g.rem = 3'd1; end
                endcase
            end
            default: begin
                g.width = 3'd6;
                case (w)
                    3'd0:    begin g.full = 8'd21; g.rem = 3'd2; end
                    3'd1:    begin g.full = 8'd26; g.rem = 3'd4; end
                    3'd2:    begin g.full = 8'd32; g.rem = 3'd0; end
                    3'd3:    begin g.full = 8'd37; g.rem = 3'd2; end
                    default: begin g.full = 8'd42; g.rem = 3'd4; end
                endcase
            end
        endcase
        // base 64 spells the tail as one binary digit per bit
        if (g.rem == 3'd0) begin
            g.expected = g.full;
        end else if (b == BASE_64) begin
            g.expected = g.full + 8'(g.rem);
        end else begin
            g.expected = g.full + 8'd1;
        end
        return g;
    endfunction

    function automatic digit_t digit_lookup(input base_t b, input logic [7:0] c);
        digit_t     d;
        logic [7:0] lc;
        d  = '0;
        lc = (c inside {["A":"Z"]}) ? c + 8'd32 : c;
        case (b)
            BASE_4: begin
                d.valid = c inside {["0":"3"]};
                d.value = DIGIT_BITS'(c - "0");
            end
            BASE_8: begin
                d.valid = c inside {["0":"7"]};
                d.value = DIGIT_BITS'(c - "0");
            end
            BASE_32: begin
                for (int i = 0; i < 32; i++) begin
                    if (BECH32_STR[255 - 8 * i -: 8] == lc) begin
                        d.valid = 1'b1;
                        d.value = DIGIT_BITS'(i);
                    end
                end
            end
            default: begin
                if (c inside {["A":"Z"]}) begin
                    d.valid = 1'b1;
                    d.value = DIGIT_BITS'(c - "A");
                end else if (c inside {["a":"z"]}) begin
                    d.valid = 1'b1;
                    d.value = DIGIT_BITS'(c - "a" + 8'd26);
                end else if (c inside {["0":"9"]}) begin
                    d.valid = 1'b1;
                    d.value = DIGIT_BITS'(c - "0" + 8'd52);
                end else if (c == "+") begin
                    d.valid = 1'b1;
                    d.value = 6'd62;
                end else if (c == "/") begin
                    d.valid = 1'b1;
                    d.value = 6'd63;
                end
            end
        endcase
        return d;
    endfunction

    // count times digit width by shift and add
    function automatic logic [10:0] times_width(input logic [7:0] n, input logic [2:0] k);
        logic [10:0] x;
        x = 11'(n);
        case (k)
            3'd2:    return x << 1;
            3'd3:    return (x << 1) + x;
            3'd5:    return (x << 2) + x;
            3'd6:    return (x << 2) + (x << 1);
            default: return '0;
        endcase
    endfunction

endpackage

// ----- rtl/entropy_base_n_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// entropy_base_n_decoder_unit
// decodes 128 to 256 bits of entropy written in base 4, 8, 32 or 64 text
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata              | tuser          | tlast
//  --------+-----------+--------------------+----------------+--------------
//  s_      | in        | char_code [7:0]    | has_char       | end_of_text
//  m_      | out       | data_byte [7:0]    | status [2:0]   | last
//  cfg_    | in        | cfg_data: register value, cfg_index: register number
//
//  one character transaction per cycle: a transaction is registered in an
//  input stage and decoded into the bit store on the following edge
//  an end marker copies the store into the result shifter; the result side
//  then sends 16 to 32 byte transactions, or one status transaction on error
//  characters keep flowing while results drain; only a second end marker
//  waits in the input stage until the result shifter is empty
//  aresetn is synchronous, active low; it clears the store and the config
//  registers back to base 64 and 24 words
//
module entropy_base_n_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_code
    input  logic [0:0]  s_tuser,       // [0] has_char
    input  logic        s_tlast,       // end_of_text

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] data_byte
    output logic [2:0]  m_tuser,       // [2:0] status
    output logic        m_tlast,       // last

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);

    import ebnd_pkg::*;

    // configuration registers
    base_t       base_sel_reg;
    logic [2:0]  word_sel_reg;

    // input stage
    logic        stg_valid_reg;
    logic [7:0]  stg_char_reg;
    logic        stg_has_reg;
    logic        stg_end_reg;

    // decode state of the current text
    store_t      store_reg;
    store_t      store_next;
    logic [7:0]  cnt_reg;
    logic [7:0]  cnt_next;
    logic        bad_char_reg;
    logic        bad_char_next;
    logic        bad_final_reg;
    logic        bad_final_next;

    // result shifter
    store_t                     out_buf_reg;
    logic [BYTE_COUNT_BITS-1:0] out_left_reg;
    status_t                    out_status_reg;

    geom_t                g;
    digit_t               dig;
    logic                 out_busy;
    logic                 stg_advance;
    logic                 fire;
    logic                 is_space;
    logic                 take;
    logic                 digit_ok;
    logic                 in_range;
    logic                 tail64;
    logic                 last_short;
    logic [10:0]          pos_wide;
    logic [POS_BITS-1:0]  pos;
    logic [DIGIT_BITS-1:0] ins_bits;
    store_t               ins_vec;
    status_t              status_now;

    assign cfg_ready = 1'b1;

    // only an end marker can be held back, and only by a busy result side
    assign out_busy    = (out_left_reg != '0);
    assign stg_advance = !(stg_end_reg && out_busy);
    assign fire        = stg_valid_reg && stg_advance;
    assign s_tready    = !stg_valid_reg || stg_advance;

    assign g   = geom(base_sel_reg, word_sel_reg);
    assign dig = digit_lookup(base_sel_reg, stg_char_reg);

    always_comb begin
        is_space   = stg_char_reg inside {[8'h09:8'h0d], 8'h20};
        take       = fire && stg_has_reg && !is_space;
        digit_ok   = take && dig.valid;
        in_range   = (cnt_reg < g.expected);
        tail64     = (base_sel_reg == BASE_64) && (cnt_reg >= g.full);
        last_short = (g.rem != 3'd0) && (cnt_reg == g.expected - 8'd1);

        bad_char_next  = bad_char_reg || (take && !dig.valid);
        bad_final_next = bad_final_reg;
        if (digit_ok && in_range && (g.rem != 3'd0)) begin
            // base 64 tail must be binary; other short digits must fit in rem bits
            if (tail64 && !(stg_char_reg == "0" || stg_char_reg == "1")) begin
                bad_final_next = 1'b1;
            end
            if ((base_sel_reg != BASE_64) && last_short &&
                ((dig.value >> g.rem) != '0)) begin
                bad_final_next = 1'b1;
            end
        end

        // bit position and left aligned bits for this digit
        if (tail64) begin
            pos_wide = times_width(g.full, g.width) + 11'(cnt_reg - g.full);
            ins_bits = {stg_char_reg[0], {(DIGIT_BITS-1){1'b0}}};
        end else if (last_short) begin
            pos_wide = times_width(g.full, g.width);
            ins_bits = dig.value << (3'(DIGIT_BITS) - g.rem);
        end else begin
            pos_wide = times_width(cnt_reg, g.width);
            ins_bits = dig.value << (3'(DIGIT_BITS) - g.width);
        end
        pos     = pos_wide[POS_BITS-1:0];
        ins_vec = store_t'({ins_bits, {(MAX_ENTROPY_BITS-DIGIT_BITS){1'b0}}}) >> pos;

        store_next = store_reg;
        if (digit_ok && in_range) begin
            store_next = store_reg | ins_vec;
        end
        cnt_next = (digit_ok && cnt_reg != 8'hff) ? cnt_reg + 8'd1 : cnt_reg;

        // checks in order: empty, bad character, bad final digit, length
        if (cnt_next == 8'd0) begin
            status_now = STATUS_EMPTY;
        end else if (bad_char_next) begin
            status_now = STATUS_BAD_CHAR;
        end else if (bad_final_next) begin
            status_now = STATUS_BAD_FINAL;
        end else if (cnt_next != g.expected) begin
            status_now = STATUS_BAD_LENGTH;
        end else begin
            status_now = STATUS_OK;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_sel_reg <= BASE_RESET;
            word_sel_reg <= WORD_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BASE_SELECT: base_sel_reg <= base_t'(cfg_data[1:0]);
                CFG_WORD_COUNT:  word_sel_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            stg_valid_reg <= 1'b1;
        end else if (stg_advance) begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stg_char_reg <= s_tdata;
            stg_has_reg  <= s_tuser[0];
            stg_end_reg  <= s_tlast;
        end
    end

    // decode state; cleared after every end marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            store_reg     <= '0;
            cnt_reg       <= '0;
            bad_char_reg  <= 1'b0;
            bad_final_reg <= 1'b0;
        end else if (fire) begin
            if (stg_end_reg) begin
                store_reg     <= '0;
                cnt_reg       <= '0;
                bad_char_reg  <= 1'b0;
                bad_final_reg <= 1'b0;
            end else begin
                store_reg     <= store_next;
                cnt_reg       <= cnt_next;
                bad_char_reg  <= bad_char_next;
                bad_final_reg <= bad_final_next;
            end
        end
    end

    // result shifter: byte count is the control, buffer and status are payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_left_reg <= '0;
        end else if (fire && stg_end_reg) begin
            out_left_reg <= (status_now == STATUS_OK) ? g.bytes : BYTE_COUNT_BITS'(1);
        end else if (m_tvalid && m_tready) begin
            out_left_reg <= out_left_reg - BYTE_COUNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && stg_end_reg) begin
            out_buf_reg    <= (status_now == STATUS_OK) ? store_next : '0;
            out_status_reg <= status_now;
        end else if (m_tvalid && m_tready) begin
            out_buf_reg <= out_buf_reg << 8;
        end
    end

    assign m_tvalid = out_busy;
    assign m_tdata  = out_buf_reg[MAX_ENTROPY_BITS-1 -: 8];
    assign m_tuser  = out_status_reg;
    assign m_tlast  = (out_left_reg == BYTE_COUNT_BITS'(1));

    // an error is a single transaction with zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tlast && m_tdata == 8'd0)
        else $error("error status not a single zero transaction");

    // an end marker that leaves the input stage always yields a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && stg_end_reg |=> m_tvalid)
        else $error("end marker produced no result");

    // the decode state is fresh after an end marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && stg_end_reg |=> cnt_reg == 8'd0 && !bad_char_reg && !bad_final_reg)
        else $error("decode state not cleared after end marker");

    // the final transaction of a run empties the result side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result side still busy after final transaction");

endmodule
